[sv/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the linear ADSR envelope pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int INDEX_WIDTH     = 3;

  // register indexes on the config port
  localparam logic [INDEX_WIDTH-1:0] REG_ATTACK_LEVEL  = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_ATTACK_TICKS  = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_DECAY_TICKS   = 3'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [INDEX_WIDTH-1:0] REG_RELEASE_TICKS = 3'd4;
  localparam logic [INDEX_WIDTH-1:0] REG_FLOOR_LEVEL   = 3'd5;

  // reset values
  localparam int RST_ATTACK_LEVEL  = 65535;
  localparam int RST_ATTACK_TICKS  = 4800;
  localparam int RST_DECAY_TICKS   = 4800;
  localparam int RST_SUSTAIN_LEVEL = 52428;
  localparam int RST_RELEASE_TICKS = 9600;
  localparam int RST_FLOOR_LEVEL   = 66;

  // held-note segment an item falls in
  typedef enum logic [1:0] {
    MODE_ATTACK,
    MODE_DECAY_UP,
    MODE_DECAY_DOWN,
    MODE_SUSTAIN
  } mode_t;

  // control flags that ride along with each beat
  typedef struct packed {
    logic  released;   // note-off at or after note-on
    logic  rel_zero;   // release done or zero length
    mode_t mode;
  } flags_t;

endpackage

`default_nettype wire

[sv/adsr_envelope_amplitude.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_amplitude
// Linear ADSR envelope amplitude from now / note-on / note-off tick counts.
// ----------------------------------------------------------------------------
// Takes one query per cycle while the output is not stalled and returns one
// level per query, in order. The pipe holds three front stages, two
// pipelined restoring dividers of LEVEL_WIDTH stages each (one quotient
// bit per stage), two stages between them and one output stage.
// A stalled output freezes the whole pipe; in_ready follows that stall.
// Registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while no query is in flight.
`default_nettype none

module adsr_envelope_amplitude #(
  parameter int TIME_WIDTH  = adsr_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = adsr_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [TIME_WIDTH-1:0]              now_ticks,
  input  wire logic [TIME_WIDTH-1:0]              on_ticks,
  input  wire logic [TIME_WIDTH-1:0]              off_ticks,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [LEVEL_WIDTH-1:0]                  level,
  input  wire logic                               cfg_we,
  input  wire logic [adsr_pkg::INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [((TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH)-1:0] cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int LW = LEVEL_WIDTH;
  localparam int FW = $bits(adsr_pkg::flags_t);

  logic [LW-1:0] attack_level;
  logic [TW-1:0] attack_ticks;
  logic [TW-1:0] decay_ticks;
  logic [LW-1:0] sustain_level;
  logic [TW-1:0] release_ticks;
  logic [LW-1:0] floor_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_level  <= LW'(adsr_pkg::RST_ATTACK_LEVEL);
      attack_ticks  <= TW'(adsr_pkg::RST_ATTACK_TICKS);
      decay_ticks   <= TW'(adsr_pkg::RST_DECAY_TICKS);
      sustain_level <= LW'(adsr_pkg::RST_SUSTAIN_LEVEL);
      release_ticks <= TW'(adsr_pkg::RST_RELEASE_TICKS);
      floor_level   <= LW'(adsr_pkg::RST_FLOOR_LEVEL);
    end else if (cfg_we) begin
      unique case (cfg_index)
        adsr_pkg::REG_ATTACK_LEVEL:  attack_level  <= cfg_data[LW-1:0];
        adsr_pkg::REG_ATTACK_TICKS:  attack_ticks  <= cfg_data[TW-1:0];
        adsr_pkg::REG_DECAY_TICKS:   decay_ticks   <= cfg_data[TW-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[LW-1:0];
        adsr_pkg::REG_RELEASE_TICKS: release_ticks <= cfg_data[TW-1:0];
        adsr_pkg::REG_FLOOR_LEVEL:   floor_level   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front
  logic             fr_valid;
  logic [TW+LW-1:0] fr_num;
  logic [TW-1:0]    fr_den;
  adsr_pkg::flags_t fr_flags;
  logic [TW-1:0]    fr_xr;

  adsr_front #(.TW(TW), .LW(LW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .now_ticks     (now_ticks),
    .on_ticks      (on_ticks),
    .off_ticks     (off_ticks),
    .attack_level  (attack_level),
    .attack_ticks  (attack_ticks),
    .decay_ticks   (decay_ticks),
    .sustain_level (sustain_level),
    .release_ticks (release_ticks),
    .out_valid     (fr_valid),
    .out_num       (fr_num),
    .out_den       (fr_den),
    .out_flags     (fr_flags),
    .out_xr        (fr_xr)
  );

  // held-level divide
  logic             d1_valid;
  logic [LW-1:0]    d1_quo;
  logic [FW+TW-1:0] d1_side;
  adsr_pkg::flags_t d1_flags;
  logic [TW-1:0]    d1_xr;

  adsr_div #(.TW(TW), .LW(LW), .SW(FW+TW)) u_div_held (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   ({fr_flags, fr_xr}),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  assign d1_flags = d1_side[FW+TW-1:TW];
  assign d1_xr    = d1_side[TW-1:0];

  // held level and release product
  logic             md_valid;
  logic [TW+LW-1:0] md_num;
  logic [TW-1:0]    md_den;
  adsr_pkg::flags_t md_flags;
  logic [LW-1:0]    md_held;

  adsr_mid #(.TW(TW), .LW(LW)) u_mid (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (d1_valid),
    .in_quo        (d1_quo),
    .in_flags      (d1_flags),
    .in_xr         (d1_xr),
    .attack_level  (attack_level),
    .sustain_level (sustain_level),
    .release_ticks (release_ticks),
    .out_valid     (md_valid),
    .out_num       (md_num),
    .out_den       (md_den),
    .out_flags     (md_flags),
    .out_held      (md_held)
  );

  // release divide
  logic             d2_valid;
  logic [LW-1:0]    d2_quo;
  logic [FW+LW-1:0] d2_side;
  adsr_pkg::flags_t d2_flags;
  logic [LW-1:0]    d2_held;

  adsr_div #(.TW(TW), .LW(LW), .SW(FW+LW)) u_div_rel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (md_valid),
    .in_num    (md_num),
    .in_den    (md_den),
    .in_side   ({md_flags, md_held}),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  assign d2_flags = d2_side[FW+LW-1:LW];
  assign d2_held  = d2_side[LW-1:0];

  // output stage: pick held or release level, apply floor
  logic [LW-1:0] lvl;

  always_comb begin
    if (d2_flags.released) begin
      lvl = d2_flags.rel_zero ? '0 : d2_quo;
    end else begin
      lvl = d2_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= (lvl <= floor_level) ? '0 : lvl;
    end
  end

endmodule

`default_nettype wire

[sv/adsr_div.sv]
// ----------------------------------------------------------------------------
// adsr_div
// Pipelined restoring divider, one quotient bit per stage. Expects the top
// TW bits of the numerator to be below the denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div #(
  parameter int TW = adsr_pkg::TIME_WIDTH_DEF,
  parameter int LW = adsr_pkg::LEVEL_WIDTH_DEF,
  parameter int SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [TW+LW-1:0] in_num,
  input  wire logic [TW-1:0]    in_den,
  input  wire logic [SW-1:0]    in_side,
  output logic                  out_valid,
  output logic [LW-1:0]         out_quo,
  output logic [SW-1:0]         out_side
);

  logic [LW-1:0] val_r;
  logic [TW-1:0] rem_r  [LW];
  logic [LW-1:0] lo_r   [LW];
  logic [TW-1:0] den_r  [LW];
  logic [SW-1:0] side_r [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    logic          val_p;
    logic [TW-1:0] rem_p;
    logic [LW-1:0] lo_p;
    logic [TW-1:0] den_p;
    logic [SW-1:0] side_p;
    logic [TW:0]   trial;
    logic [TW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign val_p  = in_valid;
      assign rem_p  = in_num[TW+LW-1:LW];
      assign lo_p   = in_num[LW-1:0];
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign val_p  = val_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign lo_p   = lo_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign trial = {rem_p, lo_p[LW-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (rst) begin
        val_r[k] <= 1'b0;
      end else if (en) begin
        val_r[k] <= val_p;
      end
    end

    // low word shifts out dividend bits and collects quotient bits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[TW-1:0] : trial[TW-1:0];
        lo_r[k]   <= {lo_p[LW-2:0], ge};
        den_r[k]  <= den_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = val_r[LW-1];
  assign out_quo   = lo_r[LW-1];
  assign out_side  = side_r[LW-1];

endmodule

`default_nettype wire

[sv/adsr_front.sv]
// ----------------------------------------------------------------------------
// adsr_front
// Elapsed times, segment decode and ramp product ahead of the first divide.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_front #(
  parameter int TW = adsr_pkg::TIME_WIDTH_DEF,
  parameter int LW = adsr_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [TW-1:0]    now_ticks,
  input  wire logic [TW-1:0]    on_ticks,
  input  wire logic [TW-1:0]    off_ticks,
  input  wire logic [LW-1:0]    attack_level,
  input  wire logic [TW-1:0]    attack_ticks,
  input  wire logic [TW-1:0]    decay_ticks,
  input  wire logic [LW-1:0]    sustain_level,
  input  wire logic [TW-1:0]    release_ticks,
  output logic                  out_valid,
  output logic [TW+LW-1:0]      out_num,
  output logic [TW-1:0]         out_den,
  output adsr_pkg::flags_t      out_flags,
  output logic [TW-1:0]         out_xr
);

  // stage 1: elapsed times
  logic          v1;
  logic          rel1;
  logic [TW-1:0] t1;
  logic [TW-1:0] e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel1 <= !(on_ticks > off_ticks);
      if (on_ticks > off_ticks) begin
        t1 <= (now_ticks >= on_ticks) ? now_ticks - on_ticks : '0;
      end else begin
        t1 <= off_ticks - on_ticks;
      end
      e1 <= (now_ticks >= off_ticks) ? now_ticks - off_ticks : '0;
    end
  end

  // stage 2: segment decode and ramp operands
  logic             v2;
  logic [TW-1:0]    x2;
  logic [LW-1:0]    y2;
  logic [TW-1:0]    z2;
  adsr_pkg::flags_t f2;
  logic [TW-1:0]    xr2;

  logic             in_atk;
  logic             in_dec;
  logic [TW-1:0]    u1;
  adsr_pkg::flags_t f1;
  logic [TW-1:0]    x1;
  logic [LW-1:0]    y1;
  logic [TW-1:0]    z1;

  assign in_atk = (attack_ticks != '0) && (t1 <= attack_ticks);
  assign u1     = t1 - attack_ticks;
  assign in_dec = (decay_ticks != '0) && (u1 <= decay_ticks);

  always_comb begin
    f1.released = rel1;
    f1.rel_zero = (release_ticks == '0) || (e1 >= release_ticks);
    x1 = '0;
    y1 = '0;
    z1 = decay_ticks;
    if (in_atk) begin
      f1.mode = adsr_pkg::MODE_ATTACK;
      x1 = t1;
      y1 = attack_level;
      z1 = attack_ticks;
    end else if (in_dec) begin
      x1 = u1;
      if (sustain_level >= attack_level) begin
        f1.mode = adsr_pkg::MODE_DECAY_UP;
        y1 = sustain_level - attack_level;
      end else begin
        f1.mode = adsr_pkg::MODE_DECAY_DOWN;
        y1 = attack_level - sustain_level;
      end
    end else begin
      f1.mode = adsr_pkg::MODE_SUSTAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= x1;
      y2  <= y1;
      z2  <= z1;
      f2  <= f1;
      xr2 <= release_ticks - e1;
    end
  end

  // stage 3: product
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num   <= x2 * y2;
      out_den   <= z2;
      out_flags <= f2;
      out_xr    <= xr2;
    end
  end

endmodule

`default_nettype wire

[sv/adsr_mid.sv]
// ----------------------------------------------------------------------------
// adsr_mid
// Held-note level from the first quotient, then the release product.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_mid #(
  parameter int TW = adsr_pkg::TIME_WIDTH_DEF,
  parameter int LW = adsr_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [LW-1:0]    in_quo,
  input  wire adsr_pkg::flags_t in_flags,
  input  wire logic [TW-1:0]    in_xr,
  input  wire logic [LW-1:0]    attack_level,
  input  wire logic [LW-1:0]    sustain_level,
  input  wire logic [TW-1:0]    release_ticks,
  output logic                  out_valid,
  output logic [TW+LW-1:0]      out_num,
  output logic [TW-1:0]         out_den,
  output adsr_pkg::flags_t      out_flags,
  output logic [LW-1:0]         out_held
);

  logic             v4;
  logic [LW-1:0]    h4;
  adsr_pkg::flags_t f4;
  logic [TW-1:0]    xr4;
  logic [LW-1:0]    h_comb;

  always_comb begin
    unique case (in_flags.mode)
      adsr_pkg::MODE_ATTACK:     h_comb = in_quo;
      adsr_pkg::MODE_DECAY_UP:   h_comb = attack_level + in_quo;
      adsr_pkg::MODE_DECAY_DOWN: h_comb = attack_level - in_quo;
      default:                   h_comb = sustain_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h4  <= h_comb;
      f4  <= in_flags;
      xr4 <= in_xr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  // remaining release time times the level at note-off
  always_ff @(posedge clk) begin
    if (en) begin
      out_num   <= xr4 * h4;
      out_den   <= release_ticks;
      out_flags <= f4;
      out_held  <= h4;
    end
  end

endmodule

`default_nettype wire

[sv/adsr_checker.sv]
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks on the envelope block's handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_checker #(
  parameter int LEVEL_WIDTH = adsr_pkg::LEVEL_WIDTH_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [LEVEL_WIDTH-1:0] level
);

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped during stall");

  a_level_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(level))
    else $error("level changed during stall");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");

endmodule

bind adsr_envelope_amplitude adsr_checker #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_adsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level     (level)
);

`default_nettype wire
